// File: src/lcdseq_pkg.sv
// Shared types and constants for the character LCD cursor sequencer.
// No dependencies; used by the top level and its checker.
package lcdseq_pkg;

  localparam int unsigned DefLineLength      = 16;
  localparam int unsigned DefHiddenShifts    = 24;
  localparam int unsigned DefScreenPositions = 32;

  localparam logic [7:0] CmdShiftRight   = 8'h14;
  localparam logic [7:0] CmdShiftLeft    = 8'h10;
  localparam logic [7:0] CmdClear        = 8'h01;
  localparam logic [7:0] ClearCodeReset  = 8'd127;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StWalk,
    StHidden,
    StData
  } seq_state_e;

endpackage

// File: src/char_lcd_cursor_sequencer.sv
// Character LCD cursor sequencer: turns input codes into LCD command/data bytes.
// Depends on lcdseq_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / code_i) takes one 8-bit code per
//   request. Output channel (out_valid_o / out_stall_i) returns LCD bytes, each
//   tagged is_data_o (data register) and last_o (final byte for that code).
//   clear_code_we_i writes clear_code_i into the clear-code register.
//   A code equal to the clear code gives one clear command and homes the cursor.
//   A code below SCREEN_POSITIONS walks the cursor there with shift commands,
//   inserting HIDDEN_SHIFTS extra shifts whenever it stands at LINE_LENGTH.
//   Any other code is written as a character and advances the cursor.
// Throughput:
//   A request is taken only while the block is idle; then one byte is
//   produced per cycle, unless out_stall_i holds it, through a single output
//   register. A walk target equal to the cursor produces nothing.
//   The cursor increment/decrement and compare unit steps once per walk
//   shift byte, but not on the hidden shifts.
// Reset: cursor goes to 0, clear code to 127, output empty, ready for a request.
// Stall: while out_stall_i holds a byte, the sequencer emits no new byte and the byte stays.
module char_lcd_cursor_sequencer import lcdseq_pkg::*; #(
  parameter int unsigned LINE_LENGTH      = DefLineLength,
  parameter int unsigned HIDDEN_SHIFTS    = DefHiddenShifts,
  parameter int unsigned SCREEN_POSITIONS = DefScreenPositions
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_code_we_i,
  input  logic [7:0] clear_code_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] lcd_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  localparam int unsigned CW = $clog2(SCREEN_POSITIONS + 1);
  localparam int unsigned HW = $clog2(HIDDEN_SHIFTS + 2);
  localparam logic [HW-1:0] HidMax = HW'(HIDDEN_SHIFTS);

  seq_state_e     state_q, state_d;
  logic [7:0]     clear_code_q;
  logic [CW-1:0]  cursor_q, cursor_d;
  logic [CW-1:0]  target_q, target_d;
  logic           up_q, up_d;
  logic           data_pend_q, data_pend_d;
  logic [HW-1:0]  hid_cnt_q, hid_cnt_d;
  logic [7:0]     char_q, char_d;

  logic           out_valid_q, out_valid_d;
  logic [7:0]     lcd_byte_q, lcd_byte_d;
  logic           is_data_q, is_data_d;
  logic           last_q, last_d;

  logic           in_accept;
  logic           can_emit;
  logic           at_line;
  logic           at_end;
  logic [CW-1:0]  cursor_step;
  logic [CW-1:0]  code_tgt;
  logic           emit;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && (state_q == StIdle);
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign at_line     = (32'(cursor_q) == LINE_LENGTH);
  assign at_end      = (32'(cursor_q) == SCREEN_POSITIONS);
  assign cursor_step = up_q ? cursor_q + CW'(1) : cursor_q - CW'(1);
  assign code_tgt    = CW'(code_i);

  assign out_valid_o = out_valid_q;
  assign lcd_byte_o  = lcd_byte_q;
  assign is_data_o   = is_data_q;
  assign last_o      = last_q;

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    target_d    = target_q;
    up_d        = up_q;
    data_pend_d = data_pend_q;
    hid_cnt_d   = hid_cnt_q;
    char_d      = char_q;
    emit        = 1'b0;
    lcd_byte_d  = lcd_byte_q;
    is_data_d   = is_data_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          hid_cnt_d = '0;
          if (code_i == clear_code_q) begin
            state_d = StClear;
          end else if (32'(code_i) < SCREEN_POSITIONS) begin
            if (code_tgt != cursor_q) begin
              state_d     = StWalk;
              target_d    = code_tgt;
              up_d        = (code_tgt > cursor_q);
              data_pend_d = 1'b0;
            end
          end else begin
            char_d = code_i;
            priority if (at_line && (HIDDEN_SHIFTS != 0)) begin
              state_d = StHidden;
            end else if (at_line) begin
              state_d = StData;
            end else if (at_end) begin
              // wrap: walk back home, then write
              state_d     = StWalk;
              target_d    = '0;
              up_d        = 1'b0;
              data_pend_d = 1'b1;
            end else begin
              state_d = StData;
            end
          end
        end
      end
      StClear: begin
        if (can_emit) begin
          emit       = 1'b1;
          lcd_byte_d = CmdClear;
          is_data_d  = 1'b0;
          last_d     = 1'b1;
          cursor_d   = '0;
          state_d    = StIdle;
        end
      end
      StWalk: begin
        if (can_emit) begin
          emit       = 1'b1;
          lcd_byte_d = up_q ? CmdShiftRight : CmdShiftLeft;
          is_data_d  = 1'b0;
          last_d     = 1'b0;
          if (at_line && (hid_cnt_q != HidMax)) begin
            hid_cnt_d = hid_cnt_q + HW'(1);
          end else begin
            hid_cnt_d = '0;
            cursor_d  = cursor_step;
            if (cursor_step == target_q) begin
              last_d  = !data_pend_q;
              state_d = data_pend_q ? StData : StIdle;
            end
          end
        end
      end
      StHidden: begin
        if (can_emit) begin
          emit       = 1'b1;
          lcd_byte_d = CmdShiftRight;
          is_data_d  = 1'b0;
          last_d     = 1'b0;
          if (hid_cnt_q == HidMax - HW'(1)) begin
            hid_cnt_d = '0;
            state_d   = StData;
          end else begin
            hid_cnt_d = hid_cnt_q + HW'(1);
          end
        end
      end
      StData: begin
        if (can_emit) begin
          emit       = 1'b1;
          lcd_byte_d = char_q;
          is_data_d  = 1'b1;
          last_d     = 1'b1;
          cursor_d   = cursor_q + CW'(1);
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // drop the held byte once taken unless a new one replaces it
    priority if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      clear_code_q <= ClearCodeReset;
      cursor_q     <= '0;
      hid_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      hid_cnt_q   <= hid_cnt_d;
      out_valid_q <= out_valid_d;
      if (clear_code_we_i) begin
        clear_code_q <= clear_code_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    up_q        <= up_d;
    data_pend_q <= data_pend_d;
    char_q      <= char_d;
    lcd_byte_q  <= lcd_byte_d;
    is_data_q   <= is_data_d;
    last_q      <= last_d;
  end

endmodule

// File: src/lcdseq_checker.sv
// Port-level checks for the character LCD cursor sequencer, bound to the top.
// Depends on lcdseq_pkg and char_lcd_cursor_sequencer.
module lcdseq_port_asserts import lcdseq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] lcd_byte_o,
  input logic       is_data_o,
  input logic       last_o
);

  // a stalled byte stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lcd_byte_o)
      && $stable(is_data_o) && $stable(last_o))
    else $error("stalled output changed");

  // a character write always closes the run for its request
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_data_o |-> last_o)
    else $error("data byte not marked last");

  // command bytes are only shifts or clear
  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> (lcd_byte_o == CmdShiftRight)
      || (lcd_byte_o == CmdShiftLeft) || (lcd_byte_o == CmdClear))
    else $error("unexpected command byte");

  // clear is a single-byte run
  a_clear_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o && (lcd_byte_o == CmdClear) |-> last_o)
    else $error("clear command not marked last");

  // hold off new requests while a run is still in progress
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("request taken in the middle of a run");

endmodule

bind char_lcd_cursor_sequencer lcdseq_port_asserts u_lcdseq_port_asserts (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .lcd_byte_o  (lcd_byte_o),
  .is_data_o   (is_data_o),
  .last_o      (last_o)
);
